// ===== rtl/core/ezr_pkg.sv =====
// ----------------------------------------------------------------------------
// ezr_pkg: shared types and constants of the ZXZ Euler point rotator
// Widths, register indexes, CORDIC constants and the coefficient microcode.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_W         = COEF_FRAC_BITS + 3;
  localparam int OUT_W          = COORD_WIDTH + 1;
  localparam int PROD_W         = COEF_W + COORD_WIDTH;
  localparam int SUM_W          = PROD_W + 3;
  localparam int ANGLE_W        = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHI   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THETA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PSI   = 2'd2;

  // CORDIC: Q30 rotation mode, angle scaled to 2^32 per turn.
  localparam int CORD_ITERS = 16;
  localparam int CORD_IT_W  = 4;
  localparam int CORD_FRAC  = 30;
  localparam int CORD_XY_W  = 33;
  localparam int CORD_Z_W   = 34;
  localparam int CORD_SH    = CORD_FRAC - COEF_FRAC_BITS;
  localparam logic signed [CORD_XY_W-1:0] CORD_X0 = 33'sd652032875;
  localparam logic signed [CORD_XY_W:0] CORD_RND =
    (CORD_SH > 0) ? (CORD_XY_W+1)'(64'sd1 <<< (CORD_SH - 1)) : '0;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef coef_t [8:0]               coef_mat_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   ocoord_t;

  typedef struct packed {
    logic  done;
    coef_t cos_v;
    coef_t sin_v;
  } cordic_res_t;

  typedef struct packed {
    logic busy;
    logic cfg_hit;
  } gen_stat_t;

  // Operand codes of the coefficient multiply-accumulate sequence.
  localparam logic [2:0] OP_CPH = 3'd0;
  localparam logic [2:0] OP_SPH = 3'd1;
  localparam logic [2:0] OP_CT  = 3'd2;
  localparam logic [2:0] OP_ST  = 3'd3;
  localparam logic [2:0] OP_CPS = 3'd4;
  localparam logic [2:0] OP_SPS = 3'd5;
  localparam logic [2:0] OP_T1  = 3'd6;
  localparam logic [2:0] OP_T2  = 3'd7;

  // Destinations: coefficients 0..8, then the two shared partial terms.
  localparam logic [3:0] DST_C0 = 4'd0;
  localparam logic [3:0] DST_C1 = 4'd1;
  localparam logic [3:0] DST_C2 = 4'd2;
  localparam logic [3:0] DST_C3 = 4'd3;
  localparam logic [3:0] DST_C4 = 4'd4;
  localparam logic [3:0] DST_C5 = 4'd5;
  localparam logic [3:0] DST_C6 = 4'd6;
  localparam logic [3:0] DST_C7 = 4'd7;
  localparam logic [3:0] DST_C8 = 4'd8;
  localparam logic [3:0] DST_T1 = 4'd9;
  localparam logic [3:0] DST_T2 = 4'd10;

  localparam logic [3:0] LAST_STEP = 4'd13;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       first;
    logic       neg;
    logic       last;
    logic [3:0] dest;
  } uop_t;

  function automatic uop_t ucode(input logic [3:0] step);
    uop_t u;
    u = '0;
    unique case (step)
      4'd0:  u = '{OP_CT,  OP_SPH, 1'b1, 1'b0, 1'b1, DST_T1};
      4'd1:  u = '{OP_CT,  OP_CPH, 1'b1, 1'b0, 1'b1, DST_T2};
      4'd2:  u = '{OP_CPS, OP_CPH, 1'b1, 1'b0, 1'b0, DST_C0};
      4'd3:  u = '{OP_SPS, OP_T1,  1'b0, 1'b1, 1'b1, DST_C0};
      4'd4:  u = '{OP_CPS, OP_SPH, 1'b1, 1'b0, 1'b0, DST_C1};
      4'd5:  u = '{OP_SPS, OP_T2,  1'b0, 1'b0, 1'b1, DST_C1};
      4'd6:  u = '{OP_SPS, OP_ST,  1'b1, 1'b0, 1'b1, DST_C2};
      4'd7:  u = '{OP_SPS, OP_CPH, 1'b1, 1'b1, 1'b0, DST_C3};
      4'd8:  u = '{OP_CPS, OP_T1,  1'b0, 1'b1, 1'b1, DST_C3};
      4'd9:  u = '{OP_CPS, OP_T2,  1'b1, 1'b0, 1'b0, DST_C4};
      4'd10: u = '{OP_SPS, OP_SPH, 1'b0, 1'b1, 1'b1, DST_C4};
      4'd11: u = '{OP_CPS, OP_ST,  1'b1, 1'b0, 1'b1, DST_C5};
      4'd12: u = '{OP_ST,  OP_SPH, 1'b1, 1'b0, 1'b1, DST_C6};
      4'd13: u = '{OP_ST,  OP_CPH, 1'b1, 1'b1, 1'b1, DST_C7};
      default: u = '0;
    endcase
    return u;
  endfunction

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [CORD_Z_W-1:0] cord_atan(input logic [CORD_IT_W-1:0] i);
    logic signed [CORD_Z_W-1:0] a;
    case (i)
      4'd0:  a = 34'sd536870912;
      4'd1:  a = 34'sd316933406;
      4'd2:  a = 34'sd167458907;
      4'd3:  a = 34'sd85004756;
      4'd4:  a = 34'sd42667331;
      4'd5:  a = 34'sd21354465;
      4'd6:  a = 34'sd10679838;
      4'd7:  a = 34'sd5340245;
      4'd8:  a = 34'sd2670163;
      4'd9:  a = 34'sd1335087;
      4'd10: a = 34'sd667544;
      4'd11: a = 34'sd333772;
      4'd12: a = 34'sd166886;
      4'd13: a = 34'sd83443;
      4'd14: a = 34'sd41722;
      default: a = 34'sd20861;
    endcase
    return a;
  endfunction

  function automatic coef_mat_t ident_mat();
    coef_mat_t m;
    m = '0;
    m[0] = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
    m[4] = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
    m[8] = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
    return m;
  endfunction

endpackage

// ===== rtl/core/euler_zxz_point_rotator.sv =====
// ----------------------------------------------------------------------------
// euler_zxz_point_rotator: ZXZ Euler rotation of fixed-point 3-vectors
// Builds A = Bz(psi) Cx(theta) Dz(phi) in Q2.15 and rotates a point per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage. Three angle registers (phi, theta, psi; binary angles, pi/32768 per
// unit) are written through the cfg_ port while no points are in flight. Each
// write rebuilds the rotation matrix: a shared CORDIC works through the three
// angles in turn, and a single multiplier then runs 14 multiply-accumulate
// steps, each a multiply state and an accumulate state, and a closing step
// that sets the last coefficient. During that time in_ready is low.
// Points arrive on the in_ valid/ready channel; one transfer can be taken in
// every cycle while the pipe is not held and no rebuild runs. Each point
// passes an input register, a product stage, a row sum stage and a rounding
// and saturating output register; out_valid rises as the result enters it.
// When out_valid is high and the receiver holds out_ready low, the whole
// pipe holds and in_ready falls; nothing is dropped or repeated.
// After reset all angles are zero, the matrix is the exact identity and the
// pipe is empty.
// ----------------------------------------------------------------------------
module euler_zxz_point_rotator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ezr_pkg::coord_t               in_x,
  input  ezr_pkg::coord_t               in_y,
  input  ezr_pkg::coord_t               in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ezr_pkg::ocoord_t              out_x,
  output ezr_pkg::ocoord_t              out_y,
  output ezr_pkg::ocoord_t              out_z,
  input  logic                          cfg_we,
  input  logic [ezr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ezr_pkg::ANGLE_W-1:0]   cfg_wdata
);
  import ezr_pkg::*;

  coef_mat_t coefs;
  gen_stat_t gstat;
  logic      adv;
  logic      in_fire;

  // Matrix builder: owns the angle registers and the coefficient set.
  ezr_coef_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs),
    .stat      (gstat)
  );

  // Points are held off while the matrix is being rebuilt, including the
  // cycle of the register write itself.
  assign in_ready = adv && !gstat.busy && !gstat.cfg_hit;
  assign in_fire  = in_valid && in_ready;

  ezr_mat_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .coefs     (coefs),
    .out_ready (out_ready),
    .adv       (adv),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

endmodule

// ===== rtl/core/ezr_cordic.sv =====
// ----------------------------------------------------------------------------
// ezr_cordic: iterative sine and cosine unit
// Rotation-mode CORDIC, one iteration per cycle.
// ----------------------------------------------------------------------------
module ezr_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ezr_pkg::angle_t      angle,
  output ezr_pkg::cordic_res_t res
);
  import ezr_pkg::*;

  logic signed [CORD_XY_W-1:0] x_r, y_r;
  logic signed [CORD_Z_W-1:0]  z_r;
  logic [CORD_IT_W-1:0]        it_r;
  logic                        run_r, done_r, neg_r;

  logic signed [ANGLE_W:0]     a_ext, a_adj;
  logic                        a_neg;
  logic signed [CORD_XY_W-1:0] dx, dy;
  logic signed [CORD_Z_W-1:0]  at;
  logic signed [CORD_XY_W:0]   xs, ys, xr, yr;

  // Fold the angle into [-pi/2, pi/2]; the results are negated at the end.
  always_comb begin
    a_ext = (ANGLE_W+1)'(angle);
    a_adj = a_ext;
    a_neg = 1'b0;
    if (a_ext > 17'sd16384) begin
      a_adj = a_ext - 17'sd32768;
      a_neg = 1'b1;
    end else if (a_ext < -17'sd16384) begin
      a_adj = a_ext + 17'sd32768;
      a_neg = 1'b1;
    end
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = cord_atan(it_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= CORD_X0;
        y_r   <= '0;
        z_r   <= CORD_Z_W'(a_adj) <<< 16;
        neg_r <= a_neg;
        it_r  <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (!z_r[CORD_Z_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        it_r <= it_r + 1'b1;
        if (it_r == CORD_IT_W'(CORD_ITERS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    xs = neg_r ? -(CORD_XY_W+1)'(x_r) : (CORD_XY_W+1)'(x_r);
    ys = neg_r ? -(CORD_XY_W+1)'(y_r) : (CORD_XY_W+1)'(y_r);
    xr = (xs + CORD_RND) >>> CORD_SH;
    yr = (ys + CORD_RND) >>> CORD_SH;
    res.done  = done_r;
    res.cos_v = xr[COEF_W-1:0];
    res.sin_v = yr[COEF_W-1:0];
  end

endmodule

// ===== rtl/core/ezr_coef_gen.sv =====
// ----------------------------------------------------------------------------
// ezr_coef_gen: angle registers and rotation matrix builder
// Runs the CORDIC over the three angles, then a multiply-accumulate sequence.
// ----------------------------------------------------------------------------
module ezr_coef_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ezr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ezr_pkg::ANGLE_W-1:0]   cfg_wdata,
  output ezr_pkg::coef_mat_t            coefs,
  output ezr_pkg::gen_stat_t            stat
);
  import ezr_pkg::*;

  localparam int ACC_W = 2 * COEF_W + 2;
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'((64'sd1 <<< (COEF_FRAC_BITS + 2)) - 1);
  localparam logic signed [ACC_W-1:0] C_MIN = -ACC_W'(64'sd1 <<< (COEF_FRAC_BITS + 2));

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CSTART = 3'd1;
  localparam logic [2:0] ST_CWAIT  = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]       state_r;
  logic [1:0]       idx_r;
  logic [3:0]       step_r;
  angle_t           phi_r, theta_r, psi_r;
  coef_t            cph_r, sph_r, ct_r, st_r, cps_r, sps_r, t1_r, t2_r;
  coef_mat_t        coef_r;
  logic signed [2*COEF_W-1:0] mprod_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic             cfg_hit;
  angle_t           cord_angle;
  cordic_res_t      cres;
  uop_t             uop;
  coef_t            op_a, op_b;
  logic signed [ACC_W-1:0] acc_sum, acc_rnd;
  coef_t            acc_val;

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_PHI || cfg_index == REG_THETA || cfg_index == REG_PSI);

  always_comb begin
    unique case (idx_r)
      2'd0:    cord_angle = phi_r;
      2'd1:    cord_angle = theta_r;
      default: cord_angle = psi_r;
    endcase
  end

  ezr_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_CSTART),
    .angle (cord_angle),
    .res   (cres)
  );

  function automatic coef_t pick(input logic [2:0] sel, input coef_t cph, input coef_t sph,
                                 input coef_t ct, input coef_t st, input coef_t cps,
                                 input coef_t sps, input coef_t t1, input coef_t t2);
    coef_t v;
    case (sel)
      OP_CPH:  v = cph;
      OP_SPH:  v = sph;
      OP_CT:   v = ct;
      OP_ST:   v = st;
      OP_CPS:  v = cps;
      OP_SPS:  v = sps;
      OP_T1:   v = t1;
      default: v = t2;
    endcase
    return v;
  endfunction

  always_comb begin
    uop  = ucode(step_r);
    op_a = pick(uop.a_sel, cph_r, sph_r, ct_r, st_r, cps_r, sps_r, t1_r, t2_r);
    op_b = pick(uop.b_sel, cph_r, sph_r, ct_r, st_r, cps_r, sps_r, t1_r, t2_r);
    acc_sum = uop.first ? '0 : acc_r;
    if (uop.neg) begin
      acc_sum = acc_sum - ACC_W'(mprod_r);
    end else begin
      acc_sum = acc_sum + ACC_W'(mprod_r);
    end
    // Round to nearest with ties upward, then saturate to the Q2 range.
    acc_rnd = (acc_sum + ACC_RND) >>> COEF_FRAC_BITS;
    if (acc_rnd > C_MAX) begin
      acc_val = C_MAX[COEF_W-1:0];
    end else if (acc_rnd < C_MIN) begin
      acc_val = C_MIN[COEF_W-1:0];
    end else begin
      acc_val = acc_rnd[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
      phi_r   <= '0;
      theta_r <= '0;
      psi_r   <= '0;
      coef_r  <= ident_mat();
    end else begin
      unique case (state_r)
        ST_CSTART: state_r <= ST_CWAIT;
        ST_CWAIT: begin
          if (cres.done) begin
            unique case (idx_r)
              2'd0: begin
                cph_r <= cres.cos_v;
                sph_r <= cres.sin_v;
              end
              2'd1: begin
                ct_r <= cres.cos_v;
                st_r <= cres.sin_v;
              end
              default: begin
                cps_r <= cres.cos_v;
                sps_r <= cres.sin_v;
              end
            endcase
            if (idx_r == 2'd2) begin
              state_r <= ST_MUL;
              step_r  <= '0;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_CSTART;
            end
          end
        end
        ST_MUL: begin
          mprod_r <= op_a * op_b;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_sum;
          if (uop.last) begin
            if (uop.dest == DST_T1) begin
              t1_r <= acc_val;
            end else if (uop.dest == DST_T2) begin
              t2_r <= acc_val;
            end else if (uop.dest <= DST_C8) begin
              coef_r[uop.dest] <= acc_val;
            end
          end
          if (step_r == LAST_STEP) begin
            state_r <= ST_FIN;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          coef_r[DST_C8] <= ct_r;
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase

      // A register write restarts the whole build from the first angle.
      if (cfg_hit) begin
        unique case (cfg_index)
          REG_PHI:   phi_r   <= cfg_wdata;
          REG_THETA: theta_r <= cfg_wdata;
          default:   psi_r   <= cfg_wdata;
        endcase
        idx_r   <= '0;
        state_r <= ST_CSTART;
      end
    end
  end

  assign coefs        = coef_r;
  assign stat.busy    = (state_r != ST_IDLE);
  assign stat.cfg_hit = cfg_hit;

endmodule

// ===== rtl/core/ezr_mat_pipe.sv =====
// ----------------------------------------------------------------------------
// ezr_mat_pipe: matrix-vector pipeline
// Input register, nine products, row sums, then rounding and saturation.
// ----------------------------------------------------------------------------
module ezr_mat_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  ezr_pkg::coord_t     in_x,
  input  ezr_pkg::coord_t     in_y,
  input  ezr_pkg::coord_t     in_z,
  input  ezr_pkg::coef_mat_t  coefs,
  input  logic                out_ready,
  output logic                adv,
  output logic                out_valid,
  output ezr_pkg::ocoord_t    out_x,
  output ezr_pkg::ocoord_t    out_y,
  output ezr_pkg::ocoord_t    out_z
);
  import ezr_pkg::*;

  localparam logic signed [SUM_W-1:0] S_RND = SUM_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] O_MAX = SUM_W'((64'sd1 <<< COORD_WIDTH) - 1);
  localparam logic signed [SUM_W-1:0] O_MIN = -SUM_W'(64'sd1 <<< COORD_WIDTH);

  logic                     v0_r, v1_r, v2_r, v3_r;
  coord_t                   p_r [3];
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [SUM_W-1:0]  sum_r [3];
  ocoord_t                  o_r [3];

  logic signed [SUM_W-1:0]  sh [3];
  ocoord_t                  sat [3];

  // The whole pipe moves together whenever the output register can take data.
  assign adv = !v3_r || out_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = sum_r[r] >>> COEF_FRAC_BITS;
      if (sh[r] > O_MAX) begin
        sat[r] = O_MAX[OUT_W-1:0];
      end else if (sh[r] < O_MIN) begin
        sat[r] = O_MIN[OUT_W-1:0];
      end else begin
        sat[r] = sh[r][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_fire;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= in_x;
      p_r[1] <= in_y;
      p_r[2] <= in_z;
      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= $signed(coefs[k]) * p_r[k % 3];
      end
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SUM_W'(prod_r[3*r]) + SUM_W'(prod_r[3*r+1]) +
                    SUM_W'(prod_r[3*r+2]) + S_RND;
      end
      for (int r = 0; r < 3; r++) begin
        o_r[r] <= sat[r];
      end
    end
  end

  assign out_valid = v3_r;
  assign out_x     = o_r[0];
  assign out_y     = o_r[1];
  assign out_z     = o_r[2];

endmodule
